### rtl/core/tbt_pkg.sv
// Shared types, character codes and helper functions of the template block tokenizer.
`default_nettype none

package tbt_pkg;

  // Most results that one input byte can cause.
  localparam int unsigned NumRes = 3;
  localparam int unsigned ResIdxW = 2;

  localparam logic [7:0] ChOpen   = 8'h7B;
  localparam logic [7:0] ChClose  = 8'h7D;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChBslash = 8'h5C;

  typedef enum logic [1:0] {
    ModeText    = 2'd0,
    ModeScript  = 2'd1,
    ModeEcho    = 2'd2,
    ModeComment = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KindText   = 3'd0,
    KindScript = 3'd1,
    KindEcho   = 3'd2,
    KindSclose = 3'd3,
    KindEclose = 3'd4,
    KindEnd    = 3'd5
  } kind_e;

  // One queue entry: the results caused by one accepted byte.
  typedef struct packed {
    logic [ResIdxW-1:0]         count;
    kind_e [NumRes-1:0]         kind;
    logic  [NumRes-1:0][7:0]    data;
    logic  [1:0]                open_block;
  } entry_t;

  // The delimiter character that is held in each mode.
  function automatic logic [7:0] hold_char(mode_e mode);
    logic [7:0] ch;
    case (mode)
      ModeText:    ch = ChOpen;
      ModeScript:  ch = ChClose;
      ModeEcho:    ch = ChEq;
      ModeComment: ch = ChHash;
      default:     ch = ChOpen;
    endcase
    return ch;
  endfunction

  // Content kind of a mode; comment mode has no content and falls back to the text code.
  function automatic kind_e content_kind(mode_e mode);
    kind_e k;
    case (mode)
      ModeText:   k = KindText;
      ModeScript: k = KindScript;
      ModeEcho:   k = KindEcho;
      default:    k = KindText;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

### rtl/core/tbt_front.sv
// Front end: tracks mode and held delimiter and classifies each byte into queue entries.
`default_nettype none

module tbt_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [7:0]      byte_in_i,
  input  wire logic            last_in_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            q_full_i,
  output logic                 push_o,
  output tbt_pkg::entry_t      entry_o
);

  tbt_pkg::mode_e mode_q, mode_d;
  logic           held_q, held_d;
  logic           accept;

  tbt_pkg::kind_e [tbt_pkg::NumRes-1:0]      ks;
  logic [tbt_pkg::NumRes-1:0][7:0]           ds;
  logic [tbt_pkg::ResIdxW-1:0]               n;
  logic [1:0]                                open_blk;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    mode_d   = mode_q;
    held_d   = held_q;
    n        = '0;
    ks       = '{default: tbt_pkg::KindText};
    ds       = '0;
    open_blk = 2'd0;

    if (held_q) begin
      held_d = 1'b0;
      if (byte_in_i == tbt_pkg::ChBslash) begin
        if (mode_d != tbt_pkg::ModeComment) begin
          ks[n] = tbt_pkg::content_kind(mode_d);
          ds[n] = tbt_pkg::hold_char(mode_d);
          n     = n + 2'd1;
        end
      end else if (mode_d == tbt_pkg::ModeText &&
                   (byte_in_i == tbt_pkg::ChOpen || byte_in_i == tbt_pkg::ChEq ||
                    byte_in_i == tbt_pkg::ChHash)) begin
        if (byte_in_i == tbt_pkg::ChOpen) begin
          mode_d = tbt_pkg::ModeScript;
        end else if (byte_in_i == tbt_pkg::ChEq) begin
          mode_d = tbt_pkg::ModeEcho;
        end else begin
          mode_d = tbt_pkg::ModeComment;
        end
      end else if (mode_d != tbt_pkg::ModeText && byte_in_i == tbt_pkg::ChClose) begin
        if (mode_d == tbt_pkg::ModeScript) begin
          ks[n] = tbt_pkg::KindSclose;
          n     = n + 2'd1;
        end else if (mode_d == tbt_pkg::ModeEcho) begin
          ks[n] = tbt_pkg::KindEclose;
          n     = n + 2'd1;
        end
        mode_d = tbt_pkg::ModeText;
      end else begin
        // The held character was not a delimiter after all.
        if (mode_d != tbt_pkg::ModeComment) begin
          ks[n] = tbt_pkg::content_kind(mode_d);
          ds[n] = tbt_pkg::hold_char(mode_d);
          n     = n + 2'd1;
        end
        if (byte_in_i == tbt_pkg::hold_char(mode_d)) begin
          held_d = 1'b1;
        end else if (mode_d != tbt_pkg::ModeComment) begin
          ks[n] = tbt_pkg::content_kind(mode_d);
          ds[n] = byte_in_i;
          n     = n + 2'd1;
        end
      end
    end else begin
      if (byte_in_i == tbt_pkg::hold_char(mode_d)) begin
        held_d = 1'b1;
      end else if (mode_d != tbt_pkg::ModeComment) begin
        ks[n] = tbt_pkg::content_kind(mode_d);
        ds[n] = byte_in_i;
        n     = n + 2'd1;
      end
    end

    if (last_in_i) begin
      if (held_d && mode_d != tbt_pkg::ModeComment) begin
        ks[n] = tbt_pkg::content_kind(mode_d);
        ds[n] = tbt_pkg::hold_char(mode_d);
        n     = n + 2'd1;
      end
      ks[n]    = tbt_pkg::KindEnd;
      ds[n]    = 8'd0;
      n        = n + 2'd1;
      open_blk = mode_d;
      mode_d   = tbt_pkg::ModeText;
      held_d   = 1'b0;
    end
  end

  assign push_o             = accept && (n != '0);
  assign entry_o.count      = n;
  assign entry_o.kind       = ks;
  assign entry_o.data       = ds;
  assign entry_o.open_block = open_blk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tbt_pkg::ModeText;
      held_q <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tbt_fifo.sv
// Short queue of classified entries between the front and back ends.
`default_nettype none

module tbt_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire tbt_pkg::entry_t wdata_i,
  input  wire logic            pop_i,
  output tbt_pkg::entry_t      rdata_o,
  output logic                 full_o,
  output logic                 empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] Full    = CW'(Depth);

  tbt_pkg::entry_t mem_q [Depth];
  logic [AW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == Full);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  occupancy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full)
    else $error("queue occupancy above depth");

endmodule

`default_nettype wire

### rtl/core/tbt_back.sv
// Back end: unpacks queue entries into single results in an output register.
`default_nettype none

module tbt_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tbt_pkg::entry_t head_i,
  input  wire logic            head_valid_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [2:0]           kind_o,
  output logic [7:0]           data_o,
  output logic [1:0]           open_block_o,
  output logic                 last_o
);

  logic [tbt_pkg::ResIdxW-1:0] idx_q, idx_d;
  logic                        valid_q, valid_d;
  tbt_pkg::kind_e              kind_q;
  logic [7:0]                  data_q;
  logic [1:0]                  open_q;
  logic                        load, is_end, at_tail;

  assign load    = head_valid_i && (!valid_q || out_ready_i);
  assign is_end  = (head_i.kind[idx_q] == tbt_pkg::KindEnd);
  assign at_tail = (idx_q == head_i.count - 2'd1);
  assign pop_o   = load && at_tail;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = at_tail ? '0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= head_i.kind[idx_q];
      data_q <= head_i.data[idx_q];
      open_q <= is_end ? head_i.open_block : 2'd0;
    end
  end

  assign out_valid_o  = valid_q;
  assign kind_o       = kind_q;
  assign data_o       = data_q;
  assign open_block_o = open_q;
  assign last_o       = (kind_q == tbt_pkg::KindEnd);

  head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> head_i.count != '0)
    else $error("queue entry without results");

  index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> idx_q < head_i.count)
    else $error("result index beyond entry count");

  idle_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> idx_q == '0)
    else $error("result index left mid-entry with empty queue");

endmodule

`default_nettype wire

### rtl/core/template_block_tokenizer.sv
// Top level of the template block tokenizer: front end, entry queue and back end.
//
// Usage: template bytes enter on the input channel (byte_in_i, last_in_i, with
// in_valid_i / in_ready_o), one transaction per byte; last_in_i marks the final
// byte of a template. Results leave on the output channel (kind_o, data_o,
// open_block_o, last_o, with out_valid_o / out_ready_i), one transaction per
// result. Kinds are text, script and echo bytes, script and echo close marks,
// and an end item that carries the block left open.
// Throughput: the front end takes one byte per cycle as long as the queue has
// room; the back end delivers one result per cycle while the receiver takes
// results, so bytes that cause two or three results can hold the input back.
// Path of a byte: its entry is written into the queue at the edge that accepts
// the byte, and its first result moves into the output register once that
// register is empty or the receiver takes the result it holds.
// Bytes that cause no result (held delimiters, comment text) never enter the
// queue.
// Reset puts the tokenizer in text mode with nothing held and empties the
// queue and the output register. When the receiver stalls, the current result
// holds in the output register, the queue fills up to FifoDepth entries, and
// then in_ready_o drops until the receiver takes results again.
`default_nettype none

module template_block_tokenizer #(
  parameter int unsigned FifoDepth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] byte_in_i,
  input  wire logic       last_in_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic [2:0]      kind_o,
  output logic [7:0]      data_o,
  output logic [1:0]      open_block_o,
  output logic            last_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i
);

  tbt_pkg::entry_t push_entry, head_entry;
  logic            push, pop, q_full, q_empty;

  // Front end: mode tracking and byte classification.
  tbt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_in_i  (byte_in_i),
    .last_in_i  (last_in_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // The queue decouples classification from result delivery.
  tbt_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (head_entry),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back end: one result per cycle into the output register while the receiver takes results.
  tbt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_entry),
    .head_valid_i (!q_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .data_o       (data_o),
    .open_block_o (open_block_o),
    .last_o       (last_o)
  );

  no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !in_ready_o)
    else $error("input accepted while queue full");

  end_carries_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> open_block_o == 2'd0)
    else $error("open block reported on a non-end result");

  close_has_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == tbt_pkg::KindSclose || kind_o == tbt_pkg::KindEclose ||
                    kind_o == tbt_pkg::KindEnd) |-> data_o == 8'd0)
    else $error("data on a mark result");

endmodule

`default_nettype wire
